// ===== sv/rhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg: shared types and constants of the RGB to HSV converter
// Widths of the pixel and result fields, the divider shape and the fixed
// constants of the hue, saturation and brightness arithmetic.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int COMP_W = 8;
	localparam int HUE_W  = 9;
	localparam int PCT_W  = 7;

	// Long-division unit: numerator, divisor and quotient widths.
	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_QUO_W = 7;

	localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
	localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
	localparam logic [13:0]      HUE_SCALE = 14'd60;

	localparam logic [DIV_NUM_W-1:0] SAT_SCALE = 16'd200;
	localparam logic [DIV_NUM_W-1:0] VAL_SCALE = 16'd200;
	localparam logic [DIV_NUM_W-1:0] VAL_BIAS  = 16'd255;
	// Brightness = (200*max + 255) / 510 through a reciprocal: 32896 = floor(2^24 / 510).
	localparam logic [31:0]          VAL_RECIP = 32'd32896;
	localparam int                   VAL_SHIFT = 24;
	localparam logic [DIV_NUM_W-1:0] VAL_DIV   = 16'd510;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [DIV_QUO_W-1:0] quo;
		logic                 rem_nz;
	} div_res_t;

	typedef struct packed {
		sector_t sector;
		logic    neg;
		logic    black;
		logic    gray;
	} side_t;

endpackage

// ===== sv/rhsv_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pix_if: pixel request channel
// Valid/ready channel that carries one 8-bit red, green, blue pixel.
// ----------------------------------------------------------------------------
interface rhsv_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rhsv_pkg::COMP_W-1:0] red;
	logic [rhsv_pkg::COMP_W-1:0] green;
	logic [rhsv_pkg::COMP_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/rhsv_hsv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_hsv_if: HSV result channel
// Valid/ready channel that carries hue, saturation and brightness.
// ----------------------------------------------------------------------------
interface rhsv_hsv_if;
	logic                       valid;
	logic                       ready;
	logic [rhsv_pkg::HUE_W-1:0] hue;
	logic [rhsv_pkg::PCT_W-1:0] saturation;
	logic [rhsv_pkg::PCT_W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

// ===== sv/rhsv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_div: pipelined restoring divider
// One quotient bit per stage, most significant first. Expects num < 128*den.
// ----------------------------------------------------------------------------
module rhsv_div (
	input  logic                                 clk,
	input  logic [rhsv_pkg::DIV_QUO_W-1:0]       en,
	input  logic [rhsv_pkg::DIV_NUM_W-1:0]       num,
	input  logic [rhsv_pkg::DIV_DEN_W-1:0]       den,
	output rhsv_pkg::div_res_t                   res
);

	localparam int NST = rhsv_pkg::DIV_QUO_W;

	logic [rhsv_pkg::DIV_NUM_W-1:0] part_s [NST];
	logic [rhsv_pkg::DIV_QUO_W-1:0] quo_s  [NST];
	logic [rhsv_pkg::DIV_DEN_W-1:0] den_s  [NST-1];

	for (genvar i = 0; i < NST; i++) begin : g_stage
		localparam int K = NST - 1 - i;
		logic [rhsv_pkg::DIV_NUM_W-1:0] part_in;
		logic [rhsv_pkg::DIV_QUO_W-1:0] quo_in;
		logic [rhsv_pkg::DIV_DEN_W-1:0] den_in;
		logic [rhsv_pkg::DIV_NUM_W-1:0] shifted;
		logic                           ge;
		logic [rhsv_pkg::DIV_QUO_W-1:0] quo_nxt;

		if (i == 0) begin : g_first
			assign part_in = num;
			assign quo_in  = '0;
			assign den_in  = den;
		end else begin : g_next
			assign part_in = part_s[i-1];
			assign quo_in  = quo_s[i-1];
			assign den_in  = den_s[i-1];
		end

		always_comb begin
			shifted    = rhsv_pkg::DIV_NUM_W'(den_in) << K;
			ge         = part_in >= shifted;
			quo_nxt    = quo_in;
			quo_nxt[K] = ge;
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				part_s[i] <= ge ? part_in - shifted : part_in;
				quo_s[i]  <= quo_nxt;
			end
		end

		// The last stage has no successor that needs the divisor.
		if (i < NST - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en[i]) begin
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign res.quo    = quo_s[NST-1];
	assign res.rem_nz = part_s[NST-1] != '0;

endmodule

// ===== sv/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top: streaming RGB to HSV converter
// Turns one 8-bit RGB pixel into hue in degrees and saturation and
// brightness in percent, through a ten-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// Usage: push pixels on pix and take results on hsv; both are valid/ready
// channels and a request moves on any edge where valid and ready are high.
// The block takes one pixel per clock unless stalled and delivers results in
// order. The depth is set by the two seven-stage long dividers (hue fraction
// and saturation) that resolve one quotient bit per stage, plus a front stage
// for max/min, a stage for the scaled numerators and an output register. Each
// stage holds its own valid bit and moves whenever the stage after it can take
// data, so bubbles close up and a stalled result does not block new pixels
// until the pipe is full. Hue is 0..359 degrees, truncated toward zero but
// rounded up for red-max pixels with blue above green; black and gray pixels
// give hue 0. Saturation and brightness are rounded to nearest, ties upward.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	rhsv_pix_if.sink          pix,
	rhsv_hsv_if.source        hsv
);

	localparam int NSTG = 10;

	// Stage valid bits and load enables, stage 1 is the input stage.
	logic [NSTG:1] valid_s;
	logic [NSTG:1] stage_en;

	always_comb begin
		stage_en[NSTG] = !valid_s[NSTG] || hsv.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stage_en[k] = !valid_s[k] || stage_en[k+1];
		end
	end

	assign pix.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (stage_en[1]) begin
				valid_s[1] <= pix.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stage_en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// ---- Stage 1: max, min, sector and signed hue difference ----
	logic [rhsv_pkg::COMP_W-1:0] mx_c, mn_c, mag_c;
	logic [rhsv_pkg::COMP_W:0]   diff_c;
	rhsv_pkg::sector_t           sector_c;

	logic [rhsv_pkg::COMP_W-1:0] mx_s1, delta_s1, mag_s1;
	rhsv_pkg::sector_t           sector_s1;
	logic                        neg_s1;

	always_comb begin
		mx_c = (pix.red > pix.green) ? pix.red : pix.green;
		mx_c = (mx_c > pix.blue) ? mx_c : pix.blue;
		mn_c = (pix.red < pix.green) ? pix.red : pix.green;
		mn_c = (mn_c < pix.blue) ? mn_c : pix.blue;
		// First maximum in the order red, green, blue picks the sector.
		if (pix.red == mx_c) begin
			sector_c = rhsv_pkg::SEC_RED;
			diff_c   = {1'b0, pix.green} - {1'b0, pix.blue};
		end else if (pix.green == mx_c) begin
			sector_c = rhsv_pkg::SEC_GREEN;
			diff_c   = {1'b0, pix.blue} - {1'b0, pix.red};
		end else begin
			sector_c = rhsv_pkg::SEC_BLUE;
			diff_c   = {1'b0, pix.red} - {1'b0, pix.green};
		end
		mag_c = diff_c[rhsv_pkg::COMP_W] ? rhsv_pkg::COMP_W'(-diff_c)
			: diff_c[rhsv_pkg::COMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			mx_s1     <= mx_c;
			delta_s1  <= mx_c - mn_c;
			mag_s1    <= mag_c;
			sector_s1 <= sector_c;
			neg_s1    <= diff_c[rhsv_pkg::COMP_W];
		end
	end

	// ---- Stage 2: scaled numerators and divisors ----
	logic [rhsv_pkg::DIV_NUM_W-1:0] hnum_s2, snum_s2, nval_s2;
	logic [rhsv_pkg::DIV_DEN_W-1:0] hden_s2, sden_s2;
	rhsv_pkg::side_t                side_s2;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			hnum_s2 <= rhsv_pkg::DIV_NUM_W'(14'(mag_s1) * rhsv_pkg::HUE_SCALE);
			hden_s2 <= rhsv_pkg::DIV_DEN_W'(delta_s1);
			snum_s2 <= rhsv_pkg::DIV_NUM_W'(delta_s1) * rhsv_pkg::SAT_SCALE
				+ rhsv_pkg::DIV_NUM_W'(mx_s1);
			sden_s2 <= {mx_s1, 1'b0};
			nval_s2 <= rhsv_pkg::DIV_NUM_W'(mx_s1) * rhsv_pkg::VAL_SCALE
				+ rhsv_pkg::VAL_BIAS;
			side_s2.sector <= sector_s1;
			side_s2.neg    <= neg_s1;
			side_s2.black  <= mx_s1 == '0;
			side_s2.gray   <= delta_s1 == '0;
		end
	end

	// ---- Stages 3 to 9: the two long dividers ----
	rhsv_pkg::div_res_t hue_div, sat_div;

	rhsv_div u_hue_div (
		.clk (clk),
		.en  (stage_en[9:3]),
		.num (hnum_s2),
		.den (hden_s2),
		.res (hue_div)
	);

	rhsv_div u_sat_div (
		.clk (clk),
		.en  (stage_en[9:3]),
		.num (snum_s2),
		.den (sden_s2),
		.res (sat_div)
	);

	// Brightness: reciprocal product in stage 3, correction in stage 4.
	logic [31:0]                    prod_s3;
	logic [rhsv_pkg::DIV_NUM_W-1:0] nval_s3;
	logic [rhsv_pkg::COMP_W-1:0]    q0_c;
	logic [rhsv_pkg::DIV_NUM_W-1:0] vrem_c;
	logic [rhsv_pkg::PCT_W-1:0]     val_c;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			prod_s3 <= 32'(nval_s2) * rhsv_pkg::VAL_RECIP;
			nval_s3 <= nval_s2;
		end
	end

	always_comb begin
		q0_c   = prod_s3[rhsv_pkg::VAL_SHIFT +: rhsv_pkg::COMP_W];
		vrem_c = nval_s3 - rhsv_pkg::DIV_NUM_W'(q0_c) * rhsv_pkg::VAL_DIV;
		// The estimate is low by at most one.
		val_c  = (vrem_c >= rhsv_pkg::VAL_DIV) ? rhsv_pkg::PCT_W'(q0_c + 8'd1)
			: q0_c[rhsv_pkg::PCT_W-1:0];
	end

	// Side data and brightness travel alongside the divider stages.
	rhsv_pkg::side_t            side_s [3:9];
	logic [rhsv_pkg::PCT_W-1:0] val_s  [4:9];

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			side_s[3] <= side_s2;
		end
		if (stage_en[4]) begin
			val_s[4] <= val_c;
		end
		for (int k = 4; k <= 9; k++) begin
			if (stage_en[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
		for (int k = 5; k <= 9; k++) begin
			if (stage_en[k]) begin
				val_s[k] <= val_s[k-1];
			end
		end
	end

	// ---- Stage 10: sector offset, wrap and special cases ----
	logic [5:0]                 hq_c;
	logic [rhsv_pkg::HUE_W-1:0] hue_c;
	logic [rhsv_pkg::HUE_W-1:0] hue_s10;
	logic [rhsv_pkg::PCT_W-1:0] sat_s10, val_s10;

	always_comb begin
		hq_c = hue_div.quo[5:0];
		case (side_s[9].sector)
			rhsv_pkg::SEC_RED: begin
				// Negative fraction wraps around by a full turn.
				hue_c = (side_s[9].neg && hq_c != '0)
					? rhsv_pkg::HUE_FULL - rhsv_pkg::HUE_W'(hq_c)
					: rhsv_pkg::HUE_W'(hq_c);
			end
			rhsv_pkg::SEC_GREEN: begin
				hue_c = side_s[9].neg
					? rhsv_pkg::HUE_GREEN - rhsv_pkg::HUE_W'(hq_c)
						- rhsv_pkg::HUE_W'(hue_div.rem_nz)
					: rhsv_pkg::HUE_GREEN + rhsv_pkg::HUE_W'(hq_c);
			end
			rhsv_pkg::SEC_BLUE: begin
				hue_c = side_s[9].neg
					? rhsv_pkg::HUE_BLUE - rhsv_pkg::HUE_W'(hq_c)
						- rhsv_pkg::HUE_W'(hue_div.rem_nz)
					: rhsv_pkg::HUE_BLUE + rhsv_pkg::HUE_W'(hq_c);
			end
			default: begin
				hue_c = '0;
			end
		endcase
		// Drop the hue for black and gray pixels.
		if (side_s[9].black || side_s[9].gray) begin
			hue_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[10]) begin
			hue_s10 <= hue_c;
			sat_s10 <= side_s[9].black ? '0 : sat_div.quo;
			val_s10 <= side_s[9].black ? '0 : val_s[9];
		end
	end

	assign hsv.valid      = valid_s[NSTG];
	assign hsv.hue        = hue_s10;
	assign hsv.saturation = sat_s10;
	assign hsv.brightness = val_s10;

endmodule
